### hw/rtl/fwrg_pkg.sv
// ----------------------------------------------------------------------------
// fwrg_pkg: shared types and constants of the flash write rate guard
// Beat payload structs, configuration bundle, register indexes and reset values.
// ----------------------------------------------------------------------------
package fwrg_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSettleDelay   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegShortWindowMs = 3'd1;
  localparam logic [CfgIdxW-1:0] RegShortLimit    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLongWindowMs  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLongLimit     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReopenPeriod  = 3'd5;

  // register reset values
  localparam logic [15:0] SettleDelayRst   = 16'd60;
  localparam logic [31:0] ShortWindowMsRst = 32'd5000;
  localparam logic [15:0] ShortLimitRst    = 16'd10;
  localparam logic [31:0] LongWindowMsRst  = 32'd3600000;
  localparam logic [15:0] LongLimitRst     = 16'd60;
  localparam logic [31:0] ReopenPeriodRst  = 32'd3600000;

  // operation codes
  localparam logic OpMarkDirty = 1'b0;
  localparam logic OpPoll      = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] ms_now;
    logic [31:0] slow_now;
    logic        power_on;
    logic        save_immediately;
  } fwrg_in_t;

  typedef struct packed {
    logic write_flash;
    logic clear_immediate;
    logic locked_out;
  } fwrg_out_t;

  typedef struct packed {
    logic [15:0] settle_delay;
    logic [31:0] short_window_ms;
    logic [15:0] short_limit;
    logic [31:0] long_window_ms;
    logic [15:0] long_limit;
    logic [31:0] reopen_period_ms;
  } fwrg_cfg_t;

endpackage

### hw/rtl/flash_write_rate_guard.sv
// ----------------------------------------------------------------------------
// flash_write_rate_guard: deferred, rate-limited flash commit controller
// Input register, one-pass decision logic, result register.
// ----------------------------------------------------------------------------
// An accepted beat waits in the input register; its result is then loaded into the result register.
// Throughput: one beat per cycle while out_ready_i drains results, set by the single pass through fwrg_core.
// The input register takes a new beat while a result waits in the output register, if it is empty.
// Reset: asynchronous, active low; clears guard state, valids and loads
// register defaults. No clearing pass.
module flash_write_rate_guard
  import fwrg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fwrg_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fwrg_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  fwrg_cfg_t cfg;
  fwrg_out_t res;
  fwrg_in_t  in_q;
  fwrg_out_t out_q;
  logic      in_valid_q, out_valid_q, proc_fire;

  fwrg_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // advance the held beat when the result slot is free or being drained
  assign proc_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;

  fwrg_core u_core (
    .clk_i,
    .rst_ni,
    .step_i (proc_fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc_fire |=> in_valid_q && $stable(in_q))
    else $error("held input beat lost or changed");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> out_valid_q)
    else $error("processed beat produced no result");

  a_empty_slot_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result slot");

  a_write_on_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res.write_flash |-> in_q.operation == OpPoll)
    else $error("flash write on a mark-dirty beat");

endmodule

### hw/rtl/fwrg_cfg_regs.sv
// ----------------------------------------------------------------------------
// fwrg_cfg_regs: configuration register bank
// Plain write port; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module fwrg_cfg_regs
  import fwrg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output fwrg_cfg_t           cfg_o
);

  fwrg_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSettleDelay:   cfg_d.settle_delay     = cfg_data_i[15:0];
        RegShortWindowMs: cfg_d.short_window_ms  = cfg_data_i;
        RegShortLimit:    cfg_d.short_limit      = cfg_data_i[15:0];
        RegLongWindowMs:  cfg_d.long_window_ms   = cfg_data_i;
        RegLongLimit:     cfg_d.long_limit       = cfg_data_i[15:0];
        RegReopenPeriod:  cfg_d.reopen_period_ms = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_delay     <= SettleDelayRst;
      cfg_q.short_window_ms  <= ShortWindowMsRst;
      cfg_q.short_limit      <= ShortLimitRst;
      cfg_q.long_window_ms   <= LongWindowMsRst;
      cfg_q.long_limit       <= LongLimitRst;
      cfg_q.reopen_period_ms <= ReopenPeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/fwrg_core.sv
// ----------------------------------------------------------------------------
// fwrg_core: commit decision and rate guard state
// Computes one result per beat and updates the guard state when step_i is set.
// ----------------------------------------------------------------------------
module fwrg_core
  import fwrg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  fwrg_in_t  item_i,
  input  fwrg_cfg_t cfg_i,
  output fwrg_out_t res_o
);

  logic        pending_q, pending_d;
  logic [31:0] pending_time_q, pending_time_d;
  logic [31:0] short_start_q, short_start_d;
  logic [31:0] short_count_q, short_count_d;
  logic [31:0] long_start_q, long_start_d;
  logic [31:0] long_count_q, long_count_d;
  logic        lockout_q, lockout_d;
  logic [31:0] reopen_time_q, reopen_time_d;

  logic [31:0] slow_diff, short_diff, long_diff, reopen_diff;
  logic [31:0] short_inc, long_inc;
  logic        settled, proceed, guarded;
  logic        short_exp, long_exp, short_trip, long_trip, lock_now;
  logic        reopen_ok, allow, write;

  always_comb begin
    slow_diff   = item_i.slow_now - pending_time_q;
    short_diff  = item_i.ms_now - short_start_q;
    long_diff   = item_i.ms_now - long_start_q;
    reopen_diff = item_i.ms_now - reopen_time_q;
    short_inc   = short_count_q + 32'd1;
    long_inc    = long_count_q + 32'd1;

    settled = slow_diff >= {16'd0, cfg_i.settle_delay};
    proceed = (item_i.operation == OpPoll) && pending_q &&
              (settled || item_i.save_immediately);
    // the guard runs only for a commit that is not an immediate save
    guarded = proceed && !item_i.save_immediately;

    short_exp  = short_diff > cfg_i.short_window_ms;
    long_exp   = long_diff > cfg_i.long_window_ms;
    short_trip = short_exp && (short_inc > {16'd0, cfg_i.short_limit});
    long_trip  = long_exp && (long_inc > {16'd0, cfg_i.long_limit});
    lock_now   = lockout_q || (guarded && (short_trip || long_trip));
    reopen_ok  = reopen_diff >= cfg_i.reopen_period_ms;
    allow      = !lock_now || (reopen_ok && item_i.power_on);
    write      = proceed && (item_i.save_immediately || allow);

    pending_d      = pending_q;
    pending_time_d = pending_time_q;
    short_start_d  = short_start_q;
    short_count_d  = short_count_q;
    long_start_d   = long_start_q;
    long_count_d   = long_count_q;
    lockout_d      = lock_now;
    reopen_time_d  = reopen_time_q;

    if (item_i.operation == OpMarkDirty) begin
      pending_d      = 1'b1;
      pending_time_d = item_i.slow_now;
    end else if (proceed) begin
      pending_d = 1'b0;
    end

    if (guarded) begin
      short_start_d = short_exp ? item_i.ms_now : short_start_q;
      short_count_d = short_exp ? 32'd0 : short_inc;
      long_start_d  = long_exp ? item_i.ms_now : long_start_q;
      long_count_d  = long_exp ? 32'd0 : long_inc;
      if (lock_now && reopen_ok) begin
        reopen_time_d = item_i.ms_now;
      end
    end

    res_o.write_flash     = write;
    res_o.clear_immediate = write;
    res_o.locked_out      = lock_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q      <= 1'b0;
      pending_time_q <= '0;
      short_start_q  <= '0;
      short_count_q  <= '0;
      long_start_q   <= '0;
      long_count_q   <= '0;
      lockout_q      <= 1'b0;
      reopen_time_q  <= '0;
    end else if (step_i) begin
      pending_q      <= pending_d;
      pending_time_q <= pending_time_d;
      short_start_q  <= short_start_d;
      short_count_q  <= short_count_d;
      long_start_q   <= long_start_d;
      long_count_q   <= long_count_d;
      lockout_q      <= lockout_d;
      reopen_time_q  <= reopen_time_d;
    end
  end

endmodule
